FILE: design/sem_pkg.sv
// ---------------------------------------------------------------------------
// sem_pkg: shared types and constants
// Sizes, register indexes and controller/datapath interface structs.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sem_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 4096;

  localparam int COL_W   = $clog2(MAX_WIDTH);       // column position
  localparam int WID_W   = COL_W + 1;               // width register
  localparam int ROW_W   = $clog2(MAX_HEIGHT);      // output row
  localparam int HGT_W   = ROW_W + 1;               // height register, input row
  localparam int PIX_W   = 8;
  localparam int GRAD_W  = 11;
  localparam int SQ_W    = 20;
  localparam int RAD_W   = SQ_W + 1;
  localparam int MAG_W   = 8;
  localparam int CFG_W   = 13;

  localparam logic [HGT_W-1:0] IN_ROW_SAT = {HGT_W{1'b1}};

  typedef enum logic [0:0] {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic take;       // latch pixel, read line stores
    logic upd;        // write lines, shift window, step positions
    logic grad;       // register gradients
    logic sq;         // register squares
    logic root_init;  // load square root unit
    logic root_step;  // one square root iteration
    logic load;       // load output register
  } sem_cmd_t;

  typedef struct packed {
    logic emit;
    logic root_done;
    logic out_stall;
  } sem_status_t;

endpackage

`default_nettype wire

FILE: design/sem_ctrl.sv
// ---------------------------------------------------------------------------
// sem_ctrl: per-beat sequencer
// Steps a beat through read, update and, on a result, gradient, square, root.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sem_ctrl import sem_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  output logic             cfg_ready_o,
  input  wire sem_status_t status_i,
  output sem_cmd_t         cmd_o
);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_UPD  = 7'b0000010,
    S_GRAD = 7'b0000100,
    S_SQ   = 7'b0001000,
    S_INIT = 7'b0010000,
    S_ROOT = 7'b0100000,
    S_OUT  = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    cfg_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o  = 1'b1;
        cfg_ready_o = ~in_valid_i;
        if (in_valid_i) begin
          cmd_o.take = 1'b1;
          state_d    = S_UPD;
        end
      end
      S_UPD: begin
        cmd_o.upd = 1'b1;
        state_d   = status_i.emit ? S_GRAD : S_IDLE;
      end
      S_GRAD: begin
        cmd_o.grad = 1'b1;
        state_d    = S_SQ;
      end
      S_SQ: begin
        cmd_o.sq = 1'b1;
        state_d  = S_INIT;
      end
      S_INIT: begin
        cmd_o.root_init = 1'b1;
        state_d         = S_ROOT;
      end
      S_ROOT: begin
        cmd_o.root_step = 1'b1;
        if (status_i.root_done) begin
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (!status_i.out_stall) begin
          cmd_o.load = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

FILE: design/sem_datapath.sv
// ---------------------------------------------------------------------------
// sem_datapath: line stores, window, gradients and square root
// Holds configuration, positions, both line stores and the output register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sem_datapath import sem_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire sem_cmd_t           cmd_i,
  output sem_status_t             status_o,
  input  wire logic [PIX_W-1:0]   pixel_i,
  input  wire logic               pad_i,
  input  wire logic               cfg_we_i,
  input  wire logic [0:0]         cfg_index_i,
  input  wire logic [CFG_W-1:0]   cfg_data_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic [MAG_W-1:0]        magnitude_o,
  output logic signed [GRAD_W-1:0] grad_x_o,
  output logic signed [GRAD_W-1:0] grad_y_o,
  output logic                    last_of_frame_o
);

  logic [WID_W-1:0] width_q;
  logic [HGT_W-1:0] height_q;
  logic [COL_W-1:0] in_col_q;
  logic [HGT_W-1:0] in_row_q;
  logic [COL_W-1:0] out_col_q;
  logic [ROW_W-1:0] out_row_q;

  logic [PIX_W-1:0] upper_mem [MAX_WIDTH];
  logic [PIX_W-1:0] lower_mem [MAX_WIDTH];
  logic [PIX_W-1:0] upper_rd_q, lower_rd_q, pix_q;

  logic [PIX_W-1:0] win_q [9];
  logic [PIX_W-1:0] win_d [9];
  logic [PIX_W-1:0] wm_q  [9];
  logic             last_q;

  logic signed [GRAD_W-1:0] gx_q, gy_q, gx_d, gy_d;
  logic [SQ_W-1:0]          sqx_q, sqy_q;
  logic signed [2*GRAD_W-1:0] sqx, sqy;
  logic [RAD_W-1:0]         rad_q, res_q, bit_q, trial;

  logic [WID_W-1:0] cfg_w;
  logic [HGT_W-1:0] cfg_h;
  logic             emit, top, bot, left, right, last;
  logic             in_col_end;
  logic [WID_W-1:0] in_col_inc, out_col_inc;
  logic [HGT_W-1:0] out_row_inc;
  logic [PIX_W+1:0] px_x, nx_x, px_y, nx_y;

  // clamp of configuration data
  always_comb begin
    cfg_w = cfg_data_i[WID_W-1:0];
    if (cfg_w < WID_W'(3)) cfg_w = WID_W'(3);
    if (cfg_w > WID_W'(MAX_WIDTH)) cfg_w = WID_W'(MAX_WIDTH);
    cfg_h = cfg_data_i[HGT_W-1:0];
    if (cfg_h < HGT_W'(3)) cfg_h = HGT_W'(3);
    if (cfg_h > HGT_W'(MAX_HEIGHT)) cfg_h = HGT_W'(MAX_HEIGHT);
  end

  assign in_col_inc  = {1'b0, in_col_q} + WID_W'(1);
  assign out_col_inc = {1'b0, out_col_q} + WID_W'(1);
  assign out_row_inc = {1'b0, out_row_q} + HGT_W'(1);
  assign in_col_end  = in_col_inc >= width_q;

  assign emit  = (in_row_q >= HGT_W'(2)) ||
                 ((in_row_q == HGT_W'(1)) && (in_col_q != '0));
  assign top   = out_row_q == '0;
  assign bot   = out_row_inc >= height_q;
  assign left  = out_col_q == '0;
  assign right = out_col_inc >= width_q;
  assign last  = bot && right;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      win_d[r*3+0] = win_q[r*3+1];
      win_d[r*3+1] = win_q[r*3+2];
    end
    win_d[2] = upper_rd_q;
    win_d[5] = lower_rd_q;
    win_d[8] = pix_q;
  end

  // line stores
  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      upper_rd_q <= upper_mem[in_col_q];
      lower_rd_q <= lower_mem[in_col_q];
      pix_q      <= pad_i ? '0 : pixel_i;
    end
    if (cmd_i.upd) begin
      upper_mem[in_col_q] <= lower_rd_q;
      lower_mem[in_col_q] <= pix_q;
    end
  end

  // config and positions
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q   <= WID_W'(640);
      height_q  <= HGT_W'(480);
      in_col_q  <= '0;
      in_row_q  <= '0;
      out_col_q <= '0;
      out_row_q <= '0;
      for (int i = 0; i < 9; i++) win_q[i] <= '0;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_IMAGE_WIDTH:  width_q  <= cfg_w;
        REG_IMAGE_HEIGHT: height_q <= cfg_h;
        default: ;
      endcase
      in_col_q  <= '0;
      in_row_q  <= '0;
      out_col_q <= '0;
      out_row_q <= '0;
    end else if (cmd_i.upd) begin
      for (int i = 0; i < 9; i++) win_q[i] <= win_d[i];
      if (emit && last) begin
        in_col_q  <= '0;
        in_row_q  <= '0;
        out_col_q <= '0;
        out_row_q <= '0;
      end else begin
        if (in_col_end) begin
          in_col_q <= '0;
          if (in_row_q != IN_ROW_SAT) in_row_q <= in_row_q + HGT_W'(1);
        end else begin
          in_col_q <= in_col_inc[COL_W-1:0];
        end
        if (emit) begin
          if (right) begin
            out_col_q <= '0;
            out_row_q <= out_row_inc[ROW_W-1:0];
          end else begin
            out_col_q <= out_col_inc[COL_W-1:0];
          end
        end
      end
    end
  end

  // masked window
  always_ff @(posedge clk_i) begin
    if (cmd_i.upd) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          wm_q[r*3+c] <= ((r == 0 && top) || (r == 2 && bot) ||
                          (c == 0 && left) || (c == 2 && right)) ? '0 : win_d[r*3+c];
        end
      end
      last_q <= last;
    end
  end

  // gradients
  always_comb begin
    px_x = {2'b0, wm_q[2]} + {1'b0, wm_q[5], 1'b0} + {2'b0, wm_q[8]};
    nx_x = {2'b0, wm_q[0]} + {1'b0, wm_q[3], 1'b0} + {2'b0, wm_q[6]};
    px_y = {2'b0, wm_q[6]} + {1'b0, wm_q[7], 1'b0} + {2'b0, wm_q[8]};
    nx_y = {2'b0, wm_q[0]} + {1'b0, wm_q[1], 1'b0} + {2'b0, wm_q[2]};
    gx_d = signed'({1'b0, px_x}) - signed'({1'b0, nx_x});
    gy_d = signed'({1'b0, px_y}) - signed'({1'b0, nx_y});
  end

  assign sqx   = gx_q * gx_q;
  assign sqy   = gy_q * gy_q;
  assign trial = res_q + bit_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.grad) begin
      gx_q <= gx_d;
      gy_q <= gy_d;
    end
    if (cmd_i.sq) begin
      sqx_q <= sqx[SQ_W-1:0];
      sqy_q <= sqy[SQ_W-1:0];
    end
    if (cmd_i.root_init) begin
      rad_q <= {1'b0, sqx_q} + {1'b0, sqy_q};
      res_q <= '0;
      bit_q <= RAD_W'(1) << (RAD_W - 1);
    end else if (cmd_i.root_step) begin
      if (rad_q >= trial) begin
        rad_q <= rad_q - trial;
        res_q <= (res_q >> 1) + bit_q;
      end else begin
        res_q <= res_q >> 1;
      end
      bit_q <= bit_q >> 2;
    end
  end

  assign status_o.emit      = emit;
  assign status_o.root_done = bit_q[0];
  assign status_o.out_stall = out_valid_o && !out_ready_i;

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (cmd_i.load) begin
      out_valid_o <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      magnitude_o     <= (res_q > RAD_W'(255)) ? '1 : res_q[MAG_W-1:0];
      grad_x_o        <= gx_q;
      grad_y_o        <= gy_q;
      last_of_frame_o <= last_q;
    end
  end

endmodule

`default_nettype wire

FILE: design/sobel_edge_magnitude.sv
// ---------------------------------------------------------------------------
// sobel_edge_magnitude: 3x3 Sobel gradient magnitude
// Streaming raster-order edge filter with two line stores.
// ---------------------------------------------------------------------------
// A beat with no result only reads and updates; one with a result also runs
// gradient, square and the 11-step iterative square root. The result for a
// pixel leaves width+1 beats after it enters; send width+1 pad beats after a
// frame to drain it. Config writes are taken only while idle and restart the
// frame. The output register lets the next beat in while a result waits.
`timescale 1ns / 1ps
`default_nettype none

module sobel_edge_magnitude import sem_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire logic [PIX_W-1:0]    pixel_i,
  input  wire logic                pad_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output logic [MAG_W-1:0]         magnitude_o,
  output logic signed [GRAD_W-1:0] grad_x_o,
  output logic signed [GRAD_W-1:0] grad_y_o,
  output logic                     last_of_frame_o,
  input  wire logic                cfg_valid_i,
  output logic                     cfg_ready_o,
  input  wire logic [0:0]          cfg_index_i,
  input  wire logic [CFG_W-1:0]    cfg_data_i
);

  sem_cmd_t    cmd;
  sem_status_t status;

  sem_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .cfg_ready_o (cfg_ready_o),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  sem_datapath u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (status),
    .pixel_i         (pixel_i),
    .pad_i           (pad_i),
    .cfg_we_i        (cfg_valid_i && cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .magnitude_o     (magnitude_o),
    .grad_x_o        (grad_x_o),
    .grad_y_o        (grad_y_o),
    .last_of_frame_o (last_of_frame_o)
  );

endmodule

`default_nettype wire

FILE: bench/testbench.sv
// ---------------------------------------------------------------------------
// testbench: self-checking bench for sobel_edge_magnitude
// Streams raster frames of several sizes through the filter and predicts
// every gradient and magnitude result. Backpressure is applied on both sides.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import sem_pkg::*;

  typedef struct packed {
    logic [MAG_W-1:0]         mag;
    logic signed [GRAD_W-1:0] gx;
    logic signed [GRAD_W-1:0] gy;
    logic                     last;
  } edge_res_t;

  typedef struct packed {
    logic [PIX_W-1:0] px;
    logic             pad;
    logic             typed;
    edge_res_t        res;
  } pix_row_t;

  localparam edge_res_t NONE = '0;
  localparam edge_res_t FLAT = '{8'd0, 11'sd0, 11'sd0, 1'b0};
  localparam edge_res_t CORNER_BR = '{8'd255, -11'sd765, -11'sd765, 1'b1};
  localparam int N_DIR = 26;

  // 3x3 frame of full white, then a mixed 3x3 frame with an inner pad and a
  // live pixel inside the drain.
  localparam pix_row_t DIR_TAB [N_DIR] = '{
    '{8'hFF, 1'b0, 1'b0, NONE}, '{8'hFF, 1'b0, 1'b0, NONE},
    '{8'hFF, 1'b0, 1'b0, NONE}, '{8'hFF, 1'b0, 1'b0, NONE},
    '{8'hFF, 1'b0, 1'b0, NONE}, '{8'hFF, 1'b0, 1'b0, NONE},
    '{8'hFF, 1'b0, 1'b0, NONE}, '{8'hFF, 1'b0, 1'b0, NONE},
    '{8'hFF, 1'b0, 1'b1, FLAT}, '{8'h00, 1'b1, 1'b0, NONE},
    '{8'h00, 1'b1, 1'b0, NONE}, '{8'h00, 1'b1, 1'b0, NONE},
    '{8'hFF, 1'b1, 1'b1, CORNER_BR},
    '{8'h00, 1'b0, 1'b0, NONE}, '{8'hFF, 1'b0, 1'b0, NONE},
    '{8'h80, 1'b0, 1'b0, NONE}, '{8'h7F, 1'b0, 1'b0, NONE},
    '{8'hFF, 1'b1, 1'b0, NONE}, '{8'h01, 1'b0, 1'b0, NONE},
    '{8'hFE, 1'b0, 1'b0, NONE}, '{8'h55, 1'b0, 1'b0, NONE},
    '{8'hAA, 1'b0, 1'b0, NONE}, '{8'h00, 1'b1, 1'b0, NONE},
    '{8'hFF, 1'b0, 1'b0, NONE}, '{8'h00, 1'b1, 1'b0, NONE},
    '{8'h00, 1'b1, 1'b0, NONE}
  };

  logic                     clk_i;
  logic                     rst_ni;
  logic                     in_valid_i;
  logic                     in_ready_o;
  logic [PIX_W-1:0]         pixel_i;
  logic                     pad_i;
  logic                     out_valid_o;
  logic                     out_ready_i;
  logic [MAG_W-1:0]         magnitude_o;
  logic signed [GRAD_W-1:0] grad_x_o;
  logic signed [GRAD_W-1:0] grad_y_o;
  logic                     last_of_frame_o;
  logic                     cfg_valid_i;
  logic                     cfg_ready_o;
  logic [0:0]               cfg_index_i;
  logic [CFG_W-1:0]         cfg_data_i;

  sobel_edge_magnitude u_dut (.*);

  // predictor state
  logic [PIX_W-1:0] upper_line [MAX_WIDTH];
  logic [PIX_W-1:0] lower_line [MAX_WIDTH];
  logic [PIX_W-1:0] win [9];
  int unsigned      img_w, img_h, in_col, in_row, out_col, out_row;

  edge_res_t pending_edges_q [$];
  int        errors, n_beats, n_results, n_frames;
  int        send_idle, recv_idle;

  function automatic void clear_pos();
    in_col = 0;
    in_row = 0;
    out_col = 0;
    out_row = 0;
  endfunction

  function automatic void cfg_predict(cfg_reg_e idx, logic [CFG_W-1:0] data);
    int unsigned v;
    if (idx == REG_IMAGE_WIDTH) begin
      v = data[WID_W-1:0];
      img_w = (v < 3) ? 3 : (v > MAX_WIDTH) ? MAX_WIDTH : v;
    end else begin
      v = data;
      img_h = (v < 3) ? 3 : (v > MAX_HEIGHT) ? MAX_HEIGHT : v;
    end
    clear_pos();
  endfunction

  function automatic bit sobel_predict(logic [PIX_W-1:0] px_in, logic pad,
                                       output edge_res_t res);
    logic [PIX_W-1:0] px;
    logic [PIX_W-1:0] col [3];
    int               w [9];
    int unsigned      x, sq, root;
    int               gx, gy;
    bit               emit, outside;
    px = pad ? '0 : px_in;
    x = (in_col >= img_w) ? 0 : in_col;
    col[0] = upper_line[x];
    col[1] = lower_line[x];
    col[2] = px;
    upper_line[x] = lower_line[x];
    lower_line[x] = px;
    for (int r = 0; r < 3; r++) begin
      win[r*3]   = win[r*3+1];
      win[r*3+1] = win[r*3+2];
      win[r*3+2] = col[r];
    end
    emit = (in_row >= 2) || (in_row == 1 && in_col >= 1);
    in_col++;
    if (in_col >= img_w) begin
      in_col = 0;
      if (in_row < 32'h1FFF) in_row++;
    end
    res = '0;
    if (!emit) return 0;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        outside = (r == 0 && out_row == 0) || (r == 2 && out_row + 1 >= img_h) ||
                  (c == 0 && out_col == 0) || (c == 2 && out_col + 1 >= img_w);
        w[r*3+c] = outside ? 0 : int'(win[r*3+c]);
      end
    end
    gx = (w[2] + 2*w[5] + w[8]) - (w[0] + 2*w[3] + w[6]);
    gy = (w[6] + 2*w[7] + w[8]) - (w[0] + 2*w[1] + w[2]);
    sq = gx*gx + gy*gy;
    root = 0;
    while (root < 255 && (root + 1) * (root + 1) <= sq) root++;
    res.mag  = root[MAG_W-1:0];
    res.gx   = gx[GRAD_W-1:0];
    res.gy   = gy[GRAD_W-1:0];
    res.last = (out_row + 1 >= img_h) && (out_col + 1 >= img_w);
    if (res.last) begin
      clear_pos();
    end else begin
      out_col++;
      if (out_col >= img_w) begin
        out_col = 0;
        out_row++;
      end
    end
    return 1;
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #20ms;
    $display("[sobel_edge_magnitude] ERROR");
    $finish;
  end

  // result side
  always @(posedge clk_i) begin
    edge_res_t exp_r;
    if (rst_ni && out_valid_o && out_ready_i) begin
      n_results++;
      if (pending_edges_q.size() == 0) begin
        $error("unexpected result beat");
        errors++;
      end else begin
        exp_r = pending_edges_q.pop_front();
        if (magnitude_o !== exp_r.mag) begin
          $error("magnitude exp %0d got %0d", exp_r.mag, magnitude_o);
          errors++;
        end
        if (grad_x_o !== exp_r.gx) begin
          $error("grad_x exp %0d got %0d", exp_r.gx, grad_x_o);
          errors++;
        end
        if (grad_y_o !== exp_r.gy) begin
          $error("grad_y exp %0d got %0d", exp_r.gy, grad_y_o);
          errors++;
        end
        if (last_of_frame_o !== exp_r.last) begin
          $error("last_of_frame exp %0d got %0d", exp_r.last, last_of_frame_o);
          errors++;
        end
      end
    end
    if (rst_ni) out_ready_i <= ($urandom_range(99) >= recv_idle);
  end

  task automatic send_pixel(logic [PIX_W-1:0] px, logic pad, bit typed = 0,
                            edge_res_t typed_res = '0);
    edge_res_t r;
    bit        has;
    while ($urandom_range(99) < send_idle) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    pixel_i    <= px;
    pad_i      <= pad;
    do @(posedge clk_i); while (!in_ready_o);
    has = sobel_predict(px, pad, r);
    n_beats++;
    if (typed) pending_edges_q.push_back(typed_res);
    else if (has) pending_edges_q.push_back(r);
  endtask

  task automatic drain_wait();
    in_valid_i <= 1'b0;
    while (pending_edges_q.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic write_cfg(cfg_reg_e idx, logic [CFG_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    cfg_predict(idx, data);
  endtask

  task automatic run_frame(int n_pix, int pad_pct, int live_drain_pct);
    for (int i = 0; i < n_pix; i++)
      send_pixel(PIX_W'($urandom), $urandom_range(99) < pad_pct);
    for (int i = 0; i <= int'(img_w); i++)
      send_pixel(PIX_W'($urandom), $urandom_range(99) >= live_drain_pct);
    n_frames++;
  endtask

  initial begin
    int w, h;
    in_valid_i  = 1'b0;
    pixel_i     = '0;
    pad_i       = 1'b0;
    out_ready_i = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = REG_IMAGE_WIDTH;
    cfg_data_i  = '0;
    errors = 0;
    n_beats = 0;
    n_results = 0;
    n_frames = 0;
    send_idle = 0;
    recv_idle = 0;
    img_w = 640;
    img_h = 480;
    clear_pos();
    foreach (upper_line[i]) begin
      upper_line[i] = '0;
      lower_line[i] = '0;
    end
    foreach (win[i]) win[i] = '0;
    rst_ni = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    write_cfg(REG_IMAGE_WIDTH, '0);
    write_cfg(REG_IMAGE_HEIGHT, 13'd2);
    for (int i = 0; i < N_DIR; i++)
      send_pixel(DIR_TAB[i].px, DIR_TAB[i].pad, DIR_TAB[i].typed, DIR_TAB[i].res);
    drain_wait();

    for (int mode = 0; mode < 3; mode++) begin
      send_idle = (mode == 0) ? 15 : (mode == 1) ? 46 : 0;
      recv_idle = (mode == 0) ? 46 : (mode == 1) ? 15 : 0;
      for (int start = n_beats; n_beats - start < 100; ) begin
        w = $urandom_range(8, 3);
        h = $urandom_range(6, 3);
        if ($urandom_range(1)) begin
          write_cfg(REG_IMAGE_WIDTH, CFG_W'(w));
          write_cfg(REG_IMAGE_HEIGHT, CFG_W'(h));
        end else begin
          write_cfg(REG_IMAGE_HEIGHT, CFG_W'(h));
          write_cfg(REG_IMAGE_WIDTH, CFG_W'(w));
        end
        if ($urandom_range(9) == 0) begin
          // frame cut short; the next write restarts it
          for (int i = $urandom_range(w * h - 1, 1); i > 0; i--)
            send_pixel(PIX_W'($urandom), $urandom_range(1));
        end else begin
          repeat ($urandom_range(2, 1)) run_frame(w * h, 5, 10);
        end
        drain_wait();
      end
    end

    // widest row, only the start of its first line
    write_cfg(REG_IMAGE_WIDTH, 13'h1FFF);
    write_cfg(REG_IMAGE_HEIGHT, 13'd3);
    for (int i = 0; i < 40; i++) send_pixel(PIX_W'($urandom), 1'b0);
    drain_wait();
    // tallest frame, only its top
    write_cfg(REG_IMAGE_WIDTH, 13'd3);
    write_cfg(REG_IMAGE_HEIGHT, 13'h1FFF);
    for (int i = 0; i < 40; i++) send_pixel(PIX_W'($urandom), 1'b0);
    drain_wait();

    $display("covered %0d frames, %0d input beats, %0d result beats checked",
             n_frames, n_beats, n_results);
    $display("sizes from 3x3 up to %0d-wide rows and %0d-row frames, clamped writes",
             MAX_WIDTH, MAX_HEIGHT);
    if (errors == 0) begin
      $display("[sobel_edge_magnitude] OK");
    end else begin
      $display("[sobel_edge_magnitude] ERROR");
    end
    $finish;
  end

endmodule

FILE: sobel_edge_magnitude.f
design/sem_pkg.sv
design/sem_ctrl.sv
design/sem_datapath.sv
design/sobel_edge_magnitude.sv
bench/testbench.sv
